/* hw/rtl/sisc_pkg.sv */
// Shared types and constants for the sorted id set compare block.
`default_nettype none

package sisc_pkg;

  // Fraction bits of the Jaccard threshold.
  localparam int unsigned FracW = 16;

  // Configuration register indexes (byte address bit 2).
  localparam logic RegOverlapMin = 1'b0;
  localparam logic RegJaccardMin = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StWalkRd,
    StWalkCmp,
    StMul,
    StReport
  } sisc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // accept one input word
    logic walk_step;  // compare the two read entries and advance
    logic mul;        // register the threshold product
    logic finish;     // present the result and clear for the next pair
  } sisc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_end;   // one of the two lists is exhausted
  } sisc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/sisc_ram.sv */
// Generic single write, single read RAM with registered read data.
`default_nettype none

module sisc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [ADDR_W-1:0]     waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic [ADDR_W-1:0]     raddr_i,
  output logic      [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/sisc_ctrl.sv */
// Controller state machine: loading, merge walk, threshold product, report.
`default_nettype none

module sisc_ctrl
  import sisc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         pair_done_i,
  input  sisc_status_t      status_i,
  output sisc_cmd_t         cmd_o,
  output logic              busy_o
);

  sisc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (pair_done_i) begin
            state_d = StWalkRd;
          end
        end
      end
      StWalkRd: begin
        // The RAMs capture the entries at the current indexes this cycle.
        if (status_i.walk_end) begin
          state_d = StMul;
        end else begin
          state_d = StWalkCmp;
        end
      end
      StWalkCmp: begin
        cmd_o.walk_step = 1'b1;
        state_d         = StWalkRd;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StReport;
      end
      StReport: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/sisc_datapath.sv */
// Datapath: list stores, counts, merge walk indexes and result logic.
`default_nettype none

module sisc_datapath
  import sisc_pkg::*;
#(
  parameter int unsigned LIST_CAPACITY = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  sisc_cmd_t         cmd_i,
  output sisc_status_t      status_o,
  input  wire logic         list_side_i,
  input  wire logic [31:0]  value_id_i,
  input  wire logic         has_value_i,
  input  wire logic [4:0]   overlap_min_i,
  input  wire logic [16:0]  jaccard_min_i,
  output logic [4:0]        shared_count_o,
  output logic [4:0]        first_size_o,
  output logic [4:0]        second_size_o,
  output logic              same_set_o,
  output logic              overlap_fires_o,
  output logic              jaccard_fires_o,
  output logic              capacity_exceeded_o
);

  localparam int unsigned CNT_W  = $clog2(LIST_CAPACITY + 1);
  localparam int unsigned IDX_W  = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int unsigned UNI_W  = CNT_W + 1;
  localparam int unsigned PROD_W = 17 + UNI_W;
  localparam int unsigned CMP_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] CapC = CNT_W'(LIST_CAPACITY);

  logic [CNT_W-1:0]  first_cnt_q, second_cnt_q;
  logic [CNT_W-1:0]  idx_a_q, idx_b_q;
  logic [CNT_W-1:0]  shared_q;
  logic              overflow_q;
  logic [PROD_W-1:0] prod_q;

  logic              we_a, we_b;
  logic [31:0]       rd_a, rd_b;
  logic [UNI_W-1:0]  union_w;
  logic [PROD_W-1:0] lhs_w;

  assign we_a = cmd_i.load && has_value_i && !list_side_i && (first_cnt_q < CapC);
  assign we_b = cmd_i.load && has_value_i && list_side_i && (second_cnt_q < CapC);

  sisc_ram #(.WIDTH(32), .DEPTH(LIST_CAPACITY)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (first_cnt_q[IDX_W-1:0]),
    .wdata_i (value_id_i),
    .raddr_i (idx_a_q[IDX_W-1:0]),
    .rdata_o (rd_a)
  );

  sisc_ram #(.WIDTH(32), .DEPTH(LIST_CAPACITY)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (second_cnt_q[IDX_W-1:0]),
    .wdata_i (value_id_i),
    .raddr_i (idx_b_q[IDX_W-1:0]),
    .rdata_o (rd_b)
  );

  assign status_o.walk_end = (idx_a_q >= first_cnt_q) || (idx_b_q >= second_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      overflow_q   <= 1'b0;
      idx_a_q      <= '0;
      idx_b_q      <= '0;
      shared_q     <= '0;
    end else begin
      if (cmd_i.load && has_value_i) begin
        if (we_a) begin
          first_cnt_q <= first_cnt_q + CNT_W'(1);
        end else if (we_b) begin
          second_cnt_q <= second_cnt_q + CNT_W'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (cmd_i.walk_step) begin
        if (rd_a == rd_b) begin
          shared_q <= shared_q + CNT_W'(1);
          idx_a_q  <= idx_a_q + CNT_W'(1);
          idx_b_q  <= idx_b_q + CNT_W'(1);
        end else if (rd_a < rd_b) begin
          idx_a_q <= idx_a_q + CNT_W'(1);
        end else begin
          idx_b_q <= idx_b_q + CNT_W'(1);
        end
      end
      if (cmd_i.finish) begin
        first_cnt_q  <= '0;
        second_cnt_q <= '0;
        overflow_q   <= 1'b0;
        idx_a_q      <= '0;
        idx_b_q      <= '0;
        shared_q     <= '0;
      end
    end
  end

  assign union_w = UNI_W'(first_cnt_q) + UNI_W'(second_cnt_q) - UNI_W'(shared_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(jaccard_min_i) * PROD_W'(union_w);
    end
  end

  assign lhs_w = PROD_W'({shared_q, {FracW{1'b0}}});

  logic [CNT_W+4:0] shared_ext, first_ext, second_ext;
  assign shared_ext = {5'b0, shared_q};
  assign first_ext  = {5'b0, first_cnt_q};
  assign second_ext = {5'b0, second_cnt_q};

  assign shared_count_o      = shared_ext[4:0];
  assign first_size_o        = first_ext[4:0];
  assign second_size_o       = second_ext[4:0];
  // The walk makes only matching steps exactly when the lists agree entry by entry.
  assign same_set_o          = (first_cnt_q == second_cnt_q) && (shared_q == first_cnt_q);
  assign overlap_fires_o     = CMP_W'(shared_q) >= CMP_W'(overlap_min_i);
  assign jaccard_fires_o     = (union_w != '0) && (lhs_w >= prod_q);
  assign capacity_exceeded_o = overflow_q;

endmodule

`default_nettype wire

/* hw/rtl/sorted_id_set_compare.sv */
// Top level of the sorted id set compare block.
//
// The block collects two lists of 32-bit ids, one input word per start pulse,
// each word tagged with its list, and on the word marked pair_done compares
// the two stored lists. A word is taken at a rising edge where start is high
// and busy is low. A word without pair_done is stored at that edge and busy
// stays low, ready for the next word. A pair_done word starts a merge walk
// over the two list stores; each walk step is a read state and a compare
// state because the list RAMs have a registered read port, and the walk makes
// at most first size plus second size steps. After the pair_done word busy
// stays high through the walk, one final exhaustion check, the Jaccard
// threshold product state and the report state. The result appears on the
// result ports for exactly one cycle, marked by done_o, and the
// receiver cannot stall it; it must take the word in that cycle. After the
// report both lists and the capacity flag are empty for the next pair. Ids
// beyond LIST_CAPACITY per list are dropped and reported through
// capacity_exceeded_o. The thresholds sit in two APB registers: the overlap
// minimum at byte address 0 and the Q16 Jaccard minimum at byte address 4;
// they should be written only while the block is idle.
`default_nettype none

module sorted_id_set_compare
  import sisc_pkg::*;
#(
  parameter int unsigned LIST_CAPACITY = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  // Input words.
  input  wire logic         start,
  output logic              busy,
  input  wire logic         list_side_i,
  input  wire logic [31:0]  value_id_i,
  input  wire logic         has_value_i,
  input  wire logic         pair_done_i,
  // Result words.
  output logic              done_o,
  output logic [4:0]        shared_count_o,
  output logic [4:0]        first_size_o,
  output logic [4:0]        second_size_o,
  output logic              same_set_o,
  output logic              overlap_fires_o,
  output logic              jaccard_fires_o,
  output logic              capacity_exceeded_o
);

  logic [4:0]   overlap_min_q;
  logic [16:0]  jaccard_min_q;
  logic         cfg_write;

  sisc_cmd_t    cmd;
  sisc_status_t status;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlap_min_q <= 5'd1;
      jaccard_min_q <= 17'd32768;
    end else if (cfg_write) begin
      if (paddr[2] == RegOverlapMin) begin
        overlap_min_q <= pwdata[4:0];
      end else begin
        jaccard_min_q <= pwdata[16:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegJaccardMin) begin
      prdata = {15'b0, jaccard_min_q};
    end else begin
      prdata = {27'b0, overlap_min_q};
    end
  end

  sisc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .pair_done_i (pair_done_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  sisc_datapath #(.LIST_CAPACITY(LIST_CAPACITY)) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .list_side_i         (list_side_i),
    .value_id_i          (value_id_i),
    .has_value_i         (has_value_i),
    .overlap_min_i       (overlap_min_q),
    .jaccard_min_i       (jaccard_min_q),
    .shared_count_o      (shared_count_o),
    .first_size_o        (first_size_o),
    .second_size_o       (second_size_o),
    .same_set_o          (same_set_o),
    .overlap_fires_o     (overlap_fires_o),
    .jaccard_fires_o     (jaccard_fires_o),
    .capacity_exceeded_o (capacity_exceeded_o)
  );

  // The report cycle is the only cycle with a valid result.
  assign done_o = cmd.finish;

endmodule

`default_nettype wire
